/* rtl/core/bpg_pkg.sv */
package bpg_pkg;

  // Default depth of the moving-average window.
  localparam int WINDOW_DEF = 10;

  localparam int PCT_W   = 7;
  localparam int VOLT_W  = 13;
  localparam int GEAR_W  = 3;
  localparam int LEVEL_W = 2;
  localparam int TICK_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECHECK_TICKS = 2'd2;

  localparam logic [PCT_W-1:0]  JUMP_LIMIT_RST    = 7'd25;
  localparam logic [TICK_W-1:0] JUMP_TICKS_RST    = 8'd10;
  localparam logic [TICK_W-1:0] RECHECK_TICKS_RST = 8'd20;

  // Reset contents of window cells, display and gear, and the percent ceiling.
  localparam logic [PCT_W-1:0] WIN_RESET   = 7'd11;
  localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
  localparam logic [GEAR_W-1:0] GEAR_RESET = 3'd1;

  // Voltage curve breakpoints in mV.
  localparam logic [VOLT_W-1:0] DIS_LO  = 13'd2600;
  localparam logic [VOLT_W-1:0] DIS_MID = 13'd3000;
  localparam logic [VOLT_W-1:0] CHG_LO  = 13'd2800;
  localparam logic [VOLT_W-1:0] CHG_MID = 13'd3300;

  // Percent at the middle breakpoint of each curve.
  localparam logic [PCT_W-1:0] DIS_MID_PCT = 7'd30;
  localparam logic [PCT_W-1:0] CHG_MID_PCT = 7'd45;

  // Each segment slope/span is a fixed-point factor; the voltage offset into a
  // segment is capped at 511 mV, which keeps the truncated quotient exact.
  localparam int RAW_SHIFT = 20;
  localparam int RAW_MUL_W = 18;
  localparam int DV_W      = 9;
  localparam logic [RAW_MUL_W-1:0] K_DIS_LO = RAW_MUL_W'(((30 << RAW_SHIFT) + 399) / 400);
  localparam logic [RAW_MUL_W-1:0] K_DIS_HI = RAW_MUL_W'(((70 << RAW_SHIFT) + 339) / 340);
  localparam logic [RAW_MUL_W-1:0] K_CHG_LO = RAW_MUL_W'(((45 << RAW_SHIFT) + 499) / 500);
  localparam logic [RAW_MUL_W-1:0] K_CHG_HI = RAW_MUL_W'(((55 << RAW_SHIFT) + 299) / 300);

  // Gear thresholds, entry 0 in the low bits.
  localparam int GEARS = 6;
  localparam logic [GEARS-1:0][PCT_W-1:0] GEAR_DIS_TAB =
    {7'd101, 7'd80, 7'd60, 7'd40, 7'd20, 7'd10};
  localparam logic [GEARS-1:0][PCT_W-1:0] GEAR_CHG_TAB =
    {7'd101, 7'd80, 7'd60, 7'd40, 7'd20, 7'd0};

  typedef struct packed {
    logic              func;
    logic [VOLT_W-1:0] voltage_mv;
    logic              charging;
  } in_t;

  typedef struct packed {
    logic [PCT_W-1:0]   percent;
    logic [GEAR_W-1:0]  gear;
    logic               report_valid;
    logic [LEVEL_W-1:0] report_level;
    logic               recheck_active;
  } out_t;

  // Window control from the tracker.
  typedef struct packed {
    logic shift;
    logic reload;
  } win_ctl_t;

endpackage

/* rtl/core/bpg_cell.sv */
module bpg_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic                      reload,
  input  logic [bpg_pkg::PCT_W-1:0] load_val,
  input  logic [bpg_pkg::PCT_W-1:0] shift_in,
  output logic [bpg_pkg::PCT_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= bpg_pkg::WIN_RESET;
    end else if (reload) begin
      value <= load_val;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

/* rtl/core/bpg_window.sv */
module bpg_window #(
  parameter int WINDOW = bpg_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bpg_pkg::win_ctl_t         ctl,
  input  logic [bpg_pkg::PCT_W-1:0] raw,
  input  logic [bpg_pkg::PCT_W-1:0] held,
  output logic [bpg_pkg::PCT_W-1:0] avg
);

  localparam int SUM_W     = $clog2(100 * WINDOW + 1);
  localparam int AVG_SHIFT = 16;
  localparam int RECIP_W   = 17;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW);
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW * 11);

  logic [bpg_pkg::PCT_W-1:0] cells [WINDOW];
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          sum_next;
  logic [PROD_W-1:0]         prod;

  // Cell 0 holds the oldest sample; the newest enters at the far end.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_last
      bpg_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ctl.shift),
        .reload   (ctl.reload),
        .load_val (held),
        .shift_in (raw),
        .value    (cells[i])
      );
    end else begin : g_mid
      bpg_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ctl.shift),
        .reload   (ctl.reload),
        .load_val (held),
        .shift_in (cells[i+1]),
        .value    (cells[i])
      );
    end
  end

  always_comb begin
    if (ctl.reload) begin
      sum_next = SUM_W'(held) * SUM_W'(WINDOW);
    end else begin
      sum_next = sum - SUM_W'(cells[0]) + SUM_W'(raw);
    end
    // Division by the window depth as a reciprocal multiply; exact over the
    // whole range of the sum.
    prod = PROD_W'(sum_next) * PROD_W'(RECIP);
    avg  = prod[AVG_SHIFT +: bpg_pkg::PCT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= SUM_RESET;
    end else if (ctl.shift || ctl.reload) begin
      sum <= sum_next;
    end
  end

endmodule

/* rtl/core/bpg_curve.sv */
module bpg_curve (
  input  logic [bpg_pkg::VOLT_W-1:0] voltage_mv,
  input  logic                       charging,
  output logic [bpg_pkg::PCT_W-1:0]  raw
);

  logic                                         zero;
  logic [bpg_pkg::VOLT_W-1:0]                   base;
  logic [bpg_pkg::RAW_MUL_W-1:0]                mult;
  logic [bpg_pkg::PCT_W-1:0]                    offset;
  logic [bpg_pkg::VOLT_W-1:0]                   dv_full;
  logic [bpg_pkg::DV_W-1:0]                     dv;
  logic [bpg_pkg::DV_W+bpg_pkg::RAW_MUL_W-1:0]  prod;
  logic [bpg_pkg::PCT_W:0]                      pct;

  always_comb begin
    zero   = 1'b0;
    base   = bpg_pkg::DIS_MID;
    mult   = bpg_pkg::K_DIS_HI;
    offset = bpg_pkg::DIS_MID_PCT;
    if (voltage_mv == '0) begin
      zero = 1'b1;
    end else if (!charging) begin
      if (voltage_mv < bpg_pkg::DIS_MID) begin
        zero   = (voltage_mv <= bpg_pkg::DIS_LO);
        base   = bpg_pkg::DIS_LO;
        mult   = bpg_pkg::K_DIS_LO;
        offset = '0;
      end
    end else begin
      base   = bpg_pkg::CHG_MID;
      mult   = bpg_pkg::K_CHG_HI;
      offset = bpg_pkg::CHG_MID_PCT;
      if (voltage_mv < bpg_pkg::CHG_MID) begin
        zero   = (voltage_mv <= bpg_pkg::CHG_LO);
        base   = bpg_pkg::CHG_LO;
        mult   = bpg_pkg::K_CHG_LO;
        offset = '0;
      end
    end

    // Offsets past 511 mV clamp to 100 percent either way.
    dv_full = voltage_mv - base;
    dv      = (dv_full > 13'd511) ? '1 : dv_full[bpg_pkg::DV_W-1:0];
    prod    = (bpg_pkg::DV_W + bpg_pkg::RAW_MUL_W)'(dv) *
              (bpg_pkg::DV_W + bpg_pkg::RAW_MUL_W)'(mult);
    pct     = (bpg_pkg::PCT_W+1)'(offset) +
              (bpg_pkg::PCT_W+1)'(prod[bpg_pkg::RAW_SHIFT +: bpg_pkg::PCT_W]);

    if (zero) begin
      raw = '0;
    end else if (pct > (bpg_pkg::PCT_W+1)'(bpg_pkg::PCT_MAX)) begin
      raw = bpg_pkg::PCT_MAX;
    end else begin
      raw = pct[bpg_pkg::PCT_W-1:0];
    end
  end

endmodule

/* rtl/core/battery_percent_gauge.sv */
// Battery percentage gauge.
// Input channel (in_valid/in_ready/in_data): one beat per sample. With func 0
// the beat carries a voltage in mV and the charge flag; the voltage is turned
// into a raw percentage, pushed through a row of window cells with a running
// sum, and the average drives a ratcheted display, a recheck mode and a gear.
// With func 1 the beat is a discharge-entry reload: the held value is copied
// into the display and into every window cell.
// Output channel (out_valid/out_ready/out_data): exactly one beat per input
// beat, in order, with percent, gear, report flag and level, and recheck flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; index 0 jump_limit, 1 jump_ticks, 2 recheck_ticks, others ignored.
// Write it only while no sample is in flight.
// From input beat to output beat there is one register stage for the voltage
// curve, then the window and tracking update that writes the output register.
// Throughput is one beat per cycle while the receiver keeps up, set by the
// loop through the running sum, the average multiply and the ratchet compare.
// When the receiver stalls, the output register holds its beat and the whole
// pipe freezes; in_ready drops only while a full output register is not taken.
// Synchronous reset restores the window to 11 in every cell, display 11, gear
// 1, and the register defaults; no clearing pass is needed.
module battery_percent_gauge #(
  parameter int WINDOW = bpg_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpg_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpg_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpg_pkg::TICK_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [bpg_pkg::PCT_W-1:0]  jump_limit;
  logic [bpg_pkg::TICK_W-1:0] jump_ticks;
  logic [bpg_pkg::TICK_W-1:0] recheck_ticks;

  // Curve stage.
  logic                      s1_valid;
  logic                      s1_func;
  logic                      s1_chg;
  logic [bpg_pkg::PCT_W-1:0] s1_raw;
  logic [bpg_pkg::PCT_W-1:0] raw;

  // Tracking state.
  logic [bpg_pkg::PCT_W-1:0]  held;
  logic [bpg_pkg::PCT_W-1:0]  shown;
  logic [bpg_pkg::GEAR_W-1:0] gear_now;
  logic [bpg_pkg::GEAR_W-1:0] gear_rep;
  logic                       fall_only;
  logic                       recheck;
  logic [bpg_pkg::TICK_W-1:0] jump_timer;

  logic [bpg_pkg::PCT_W-1:0]  held_next;
  logic [bpg_pkg::PCT_W-1:0]  shown_next;
  logic [bpg_pkg::GEAR_W-1:0] gear_now_next;
  logic                       fall_only_next;
  logic                       recheck_next;
  logic [bpg_pkg::TICK_W-1:0] jump_timer_next;
  logic                       rep;
  bpg_pkg::out_t              result;

  logic                       adv;
  logic                       step;
  bpg_pkg::win_ctl_t          win_ctl;
  logic [bpg_pkg::PCT_W-1:0]  avg;

  // The pipe moves whenever the output register is free or being emptied.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign step      = adv && s1_valid;

  assign win_ctl.shift  = step && !s1_func;
  assign win_ctl.reload = step && s1_func;

  bpg_curve u_curve (
    .voltage_mv (in_data.voltage_mv),
    .charging   (in_data.charging),
    .raw        (raw)
  );

  bpg_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .ctl  (win_ctl),
    .raw  (s1_raw),
    .held (held),
    .avg  (avg)
  );

  always_comb begin
    logic [bpg_pkg::PCT_W-1:0]            cur;
    logic [bpg_pkg::TICK_W:0]             tick;
    logic [bpg_pkg::GEARS-1:0][bpg_pkg::PCT_W-1:0] tab;
    logic                                 found;

    held_next       = held;
    shown_next      = shown;
    gear_now_next   = gear_now;
    fall_only_next  = fall_only;
    recheck_next    = recheck;
    jump_timer_next = jump_timer;
    rep             = 1'b0;
    cur             = avg;
    tick            = {1'b0, jump_timer} + 9'd1;
    tab             = s1_chg ? bpg_pkg::GEAR_CHG_TAB : bpg_pkg::GEAR_DIS_TAB;
    found           = 1'b0;

    if (s1_func) begin
      shown_next     = held;
      fall_only_next = 1'b1;
    end else begin
      // Ratchet: fall only while discharging, rise only while charging.
      if (!s1_chg) begin
        if (held > avg) begin
          fall_only_next = 1'b0;
          held_next      = avg;
          if (avg == '0) begin
            cur = 7'd1;
          end
          shown_next = cur;
        end
      end else if (held < avg) begin
        held_next  = avg;
        shown_next = avg;
      end

      // Recheck mode follows the average; sustained upward jumps enter it.
      if (recheck) begin
        if (tick > {1'b0, recheck_ticks}) begin
          recheck_next    = 1'b0;
          jump_timer_next = '0;
        end else begin
          jump_timer_next = tick[bpg_pkg::TICK_W-1:0];
        end
        held_next  = cur;
        shown_next = cur;
      end else if (!s1_chg && !fall_only_next && cur > held_next &&
                   (cur - held_next) >= jump_limit) begin
        if (tick > {1'b0, jump_ticks}) begin
          jump_timer_next = '0;
          recheck_next    = 1'b1;
        end else begin
          jump_timer_next = tick[bpg_pkg::TICK_W-1:0];
        end
      end else begin
        jump_timer_next = '0;
      end

      // First threshold above the display picks the gear.
      for (int i = 0; i < bpg_pkg::GEARS; i++) begin
        if (!found && shown_next < tab[i]) begin
          gear_now_next = bpg_pkg::GEAR_W'(i);
          found         = 1'b1;
        end
      end

      rep = (gear_rep != gear_now_next);
    end

    result.percent        = shown_next;
    result.gear           = gear_now_next;
    result.report_valid   = rep;
    result.report_level   = rep ? gear_now_next[bpg_pkg::GEAR_W-1:1] : '0;
    result.recheck_active = recheck_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit    <= bpg_pkg::JUMP_LIMIT_RST;
      jump_ticks    <= bpg_pkg::JUMP_TICKS_RST;
      recheck_ticks <= bpg_pkg::RECHECK_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpg_pkg::REG_JUMP_LIMIT:    jump_limit    <= cfg_data[bpg_pkg::PCT_W-1:0];
        bpg_pkg::REG_JUMP_TICKS:    jump_ticks    <= cfg_data;
        bpg_pkg::REG_RECHECK_TICKS: recheck_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func <= in_data.func;
      s1_chg  <= in_data.charging;
      s1_raw  <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      shown      <= bpg_pkg::WIN_RESET;
      gear_now   <= bpg_pkg::GEAR_RESET;
      gear_rep   <= '0;
      fall_only  <= 1'b0;
      recheck    <= 1'b0;
      jump_timer <= '0;
    end else if (step) begin
      held       <= held_next;
      shown      <= shown_next;
      gear_now   <= gear_now_next;
      fall_only  <= fall_only_next;
      recheck    <= recheck_next;
      jump_timer <= jump_timer_next;
      if (rep) begin
        gear_rep <= gear_now_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default window depth, so the predictor uses the same.
  localparam int WIN = bpg_pkg::WINDOW_DEF;

  // Hard stop for the run. The slowest legal run is far below this.
  localparam int CYCLE_LIMIT = 500000;

  // Index 3 is not mapped to any register. A write there must change nothing.
  localparam logic [bpg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  bpg_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_ready;
  bpg_pkg::out_t                 out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bpg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bpg_pkg::TICK_W-1:0]    cfg_data;

  battery_percent_gauge u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock, low half first so time zero carries no rising edge.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Gauge predictor state. This mirrors the block's window, display ratchet,
  // recheck tracker and gear/report registers, plus its three settings.
  // ---------------------------------------------------------------------------
  logic [bpg_pkg::PCT_W-1:0]  win_q [WIN];
  logic [bpg_pkg::PCT_W-1:0]  held_pct;
  logic [bpg_pkg::PCT_W-1:0]  shown_pct;
  logic [bpg_pkg::GEAR_W-1:0] gear_cur;
  logic [bpg_pkg::GEAR_W-1:0] gear_sent;
  bit                         fall_only;
  bit                         recheck_on;
  logic [bpg_pkg::TICK_W-1:0] jump_tmr;
  logic [bpg_pkg::PCT_W-1:0]  jump_limit_r;
  logic [bpg_pkg::TICK_W-1:0] jump_ticks_r;
  logic [bpg_pkg::TICK_W-1:0] recheck_ticks_r;

  // Gauge readings still owed by the block, oldest first.
  bpg_pkg::out_t gauge_expect [$];

  int unsigned cycle_cnt;
  int          err_cnt;
  int          sent_cnt;
  // Receiver hold-off requested by a test, counted down by the sink process.
  int          hold_left;
  int          sink_gap;
  // Random idling on the sender and receiver sides can be switched off per phase.
  bit          tx_idle_on;
  bit          rx_idle_on;

  task automatic model_reset();
    for (int i = 0; i < WIN; i++) win_q[i] = bpg_pkg::WIN_RESET;
    held_pct        = '0;
    shown_pct       = bpg_pkg::WIN_RESET;
    gear_cur        = bpg_pkg::GEAR_RESET;
    gear_sent       = '0;
    fall_only       = 1'b0;
    recheck_on      = 1'b0;
    jump_tmr        = '0;
    jump_limit_r    = bpg_pkg::JUMP_LIMIT_RST;
    jump_ticks_r    = bpg_pkg::JUMP_TICKS_RST;
    recheck_ticks_r = bpg_pkg::RECHECK_TICKS_RST;
  endtask

  // Piecewise-linear voltage curve with truncating divides, clamped to 100.
  // Discharging bends at 2600/3000 mV, charging at 2800/3300 mV.
  function automatic int raw_pct(int mv, bit chg);
    int p;
    if (mv == 0) return 0;
    if (!chg) begin
      if (mv < 3000) p = (mv > 2600) ? (mv - 2600) * 30 / 400 : 0;
      else p = 30 + (mv - 3000) * 70 / 340;
    end else begin
      if (mv < 3300) p = (mv > 2800) ? (mv - 2800) * 45 / 500 : 0;
      else p = 45 + (mv - 3300) * 55 / 300;
    end
    return (p > 100) ? 100 : p;
  endfunction

  // Gear thresholds. The two tables differ only in their first step.
  function automatic int gear_step(bit chg, int idx);
    case (idx)
      0:       return chg ? 0 : 10;
      1:       return 20;
      2:       return 40;
      3:       return 60;
      4:       return 80;
      default: return 101;
    endcase
  endfunction

  // Advances the predictor by one input beat and returns the reading the block
  // must produce for it.
  function automatic bpg_pkg::out_t gauge_step(bpg_pkg::in_t beat);
    bpg_pkg::out_t r;
    int   sum;
    int   avg;
    int   nxt;
    int   g;
    bit   rep;
    rep = 1'b0;
    if (beat.func) begin
      // Discharge entry: the held value refills the display and the window.
      shown_pct = held_pct;
      for (int i = 0; i < WIN; i++) win_q[i] = held_pct;
      fall_only = 1'b1;
    end else begin
      for (int i = 0; i < WIN - 1; i++) win_q[i] = win_q[i + 1];
      win_q[WIN - 1] = bpg_pkg::PCT_W'(raw_pct(int'(beat.voltage_mv), beat.charging));
      sum = 0;
      for (int i = 0; i < WIN; i++) sum += int'(win_q[i]);
      avg = sum / WIN;

      // Ratchet: falls only while discharging, rises only while charging.
      // A fall to zero is held as zero but shown as one, and that one is also
      // what the jump compare below sees.
      if (!beat.charging) begin
        if (held_pct > avg) begin
          fall_only = 1'b0;
          held_pct  = bpg_pkg::PCT_W'(avg);
          if (avg == 0) avg = 1;
          shown_pct = bpg_pkg::PCT_W'(avg);
        end
      end else if (held_pct < avg) begin
        held_pct  = bpg_pkg::PCT_W'(avg);
        shown_pct = bpg_pkg::PCT_W'(avg);
      end

      nxt = int'(jump_tmr) + 1;
      if (recheck_on) begin
        if (nxt > recheck_ticks_r) begin
          recheck_on = 1'b0;
          jump_tmr   = '0;
        end else begin
          jump_tmr = bpg_pkg::TICK_W'(nxt);
        end
        held_pct  = bpg_pkg::PCT_W'(avg);
        shown_pct = bpg_pkg::PCT_W'(avg);
      end else if (!beat.charging && !fall_only && avg > held_pct &&
                   avg - held_pct >= jump_limit_r) begin
        if (nxt > jump_ticks_r) begin
          jump_tmr   = '0;
          recheck_on = 1'b1;
        end else begin
          jump_tmr = bpg_pkg::TICK_W'(nxt);
        end
      end else begin
        jump_tmr = '0;
      end

      for (g = 0; g < 6; g++) begin
        if (shown_pct < gear_step(beat.charging, g)) break;
      end
      if (g < 6) gear_cur = bpg_pkg::GEAR_W'(g);
      if (gear_cur >= 6) gear_cur = '0;

      if (gear_sent != gear_cur) begin
        gear_sent = gear_cur;
        rep       = 1'b1;
      end
    end
    r.percent        = shown_pct;
    r.gear           = gear_cur;
    r.report_valid   = rep;
    r.report_level   = rep ? bpg_pkg::LEVEL_W'(gear_cur / 2) : '0;
    r.recheck_active = recheck_on;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side. All handshake signals are read right after the rising edge,
  // before any register update of that edge lands, so both the block and the
  // testbench see the same pre-edge values.
  // ---------------------------------------------------------------------------
  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    bpg_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (gauge_expect.size() == 0) begin
        $error("result beat %h arrived with nothing expected", out_data);
        err_cnt++;
      end else begin
        want = gauge_expect.pop_front();
        cmp_field("percent", 8'(want.percent), 8'(out_data.percent));
        cmp_field("gear", 8'(want.gear), 8'(out_data.gear));
        cmp_field("report_valid", 8'(want.report_valid), 8'(out_data.report_valid));
        cmp_field("report_level", 8'(want.report_level), 8'(out_data.report_level));
        cmp_field("recheck_active", 8'(want.recheck_active),
                  8'(out_data.recheck_active));
      end
    end
  end

  // Receiver. A requested hold-off wins over everything but reset; otherwise random
  // stalls are drawn when idling is enabled for the current phase.
  always @(posedge clk) begin : sink_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap--;
    end else if (rx_idle_on && $urandom_range(0, 9) < 3) begin
      out_ready <= 1'b0;
      sink_gap = pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task here starts in a time step right after a rising
  // edge in which in_valid has not been assigned yet. send_beat leaves valid
  // high after its beat is taken, so back-to-back beats never drop it; the
  // next call or drain decides what happens to it.
  // ---------------------------------------------------------------------------
  task automatic send_beat(bpg_pkg::in_t beat);
    int gap;
    if (tx_idle_on && $urandom_range(0, 9) < 3) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The beat is taken at this edge; predict its reading in acceptance order.
    gauge_expect.push_back(gauge_step(beat));
    sent_cnt++;
  endtask

  task automatic send_sample(bit chg, int mv);
    bpg_pkg::in_t b;
    b.func       = 1'b0;
    b.voltage_mv = bpg_pkg::VOLT_W'(mv);
    b.charging   = chg;
    send_beat(b);
  endtask

  // Voltage and charge flag are don't-care on a reload, so they get random bits.
  task automatic send_reload();
    bpg_pkg::in_t b;
    b.func       = 1'b1;
    b.voltage_mv = bpg_pkg::VOLT_W'($urandom_range(0, 4500));
    b.charging   = 1'($urandom_range(0, 1));
    send_beat(b);
  endtask

  task automatic send_run(bit chg, int mv_lo, int mv_hi, int n);
    repeat (n) send_sample(chg, $urandom_range(mv_lo, mv_hi));
  endtask

  // Stops offering beats and waits until every owed reading has come back,
  // then lets the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (gauge_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called after drain, so nothing is in flight.
  task automatic write_reg(logic [bpg_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpg_pkg::TICK_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bpg_pkg::REG_JUMP_LIMIT:    jump_limit_r    = val[bpg_pkg::PCT_W-1:0];
      bpg_pkg::REG_JUMP_TICKS:    jump_ticks_r    = val;
      bpg_pkg::REG_RECHECK_TICKS: recheck_ticks_r = val;
      default: ;
    endcase
  endtask

  // Well-formed sample sequences with random content, and some noise.
  task automatic random_traffic(int budget);
    int stop_at;
    int kind;
    int base;
    int n;
    int mv0;
    int stride;
    stop_at = sent_cnt + budget;
    while (sent_cnt < stop_at) begin
      kind = $urandom_range(0, 9);
      base = $urandom_range(2400, 4400);
      case (kind)
        0, 1, 2, 3: begin
          // Steady battery around one voltage, either direction.
          send_run(1'($urandom_range(0, 1)), base - 60, base + 60, $urandom_range(3, 30));
        end
        4, 5: begin
          // Drop the display while discharging, then jump back up; this is
          // the path into and out of recheck mode.
          send_run(1'b0, 0, 2700, $urandom_range(8, 14));
          send_run(1'b0, 3300, 4500, $urandom_range(10, 40));
        end
        6: begin
          // Unplugged: discharge entry reload followed by a slow sag.
          send_reload();
          send_run(1'b0, base - 150, base, $urandom_range(5, 25));
        end
        7: begin
          // Charging ramp from a random start, pinned at the top voltage.
          n      = $urandom_range(10, 25);
          mv0    = $urandom_range(2700, 3400);
          stride = $urandom_range(5, 40);
          for (int k = 0; k < n; k++) begin
            send_sample(1'b1, (mv0 + k * stride > 4500) ? 4500 : mv0 + k * stride);
          end
        end
        default: begin
          // Noise: anything the fields allow, including stray reloads.
          repeat (3) begin
            if ($urandom_range(0, 3) == 0) send_reload();
            else send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 4500));
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Curve corners of both branches under the reset settings: zero reading,
  // the low breakpoint (discharging only), first nonzero step, both sides of the
  // middle breakpoint, the last value under the clamp and the clamp itself.
  task automatic test_curve_points();
    send_sample(1'b0, 0);
    send_sample(1'b0, 2600);
    send_sample(1'b0, 2614);
    send_sample(1'b0, 2999);
    send_sample(1'b0, 3000);
    send_sample(1'b0, 3339);
    send_sample(1'b0, 3340);
    send_sample(1'b0, 4500);
    send_sample(1'b1, 0);
    send_sample(1'b1, 2812);
    send_sample(1'b1, 3299);
    send_sample(1'b1, 3300);
    send_sample(1'b1, 3599);
    send_sample(1'b1, 3600);
    drain();
  endtask

  // Reload copies the held value into display and window. Ten dead readings
  // while discharging pull the average to zero, which must show as one; the
  // following reload then shows the held zero.
  task automatic test_reload_floor();
    send_reload();
    repeat (WIN) send_sample(1'b0, 0);
    send_reload();
    drain();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // beats with no gaps, so the block fills and must hold off its input.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_left  = 200;
    random_traffic(40);
    drain();
    tx_idle_on = 1'b1;
  endtask

  // Random traffic in phases, each with its own settings and idling mix.
  // The first phase sets all three to one; the second sets a jump limit of 100 and both tick settings at their highest.
  task automatic test_random_phases();
    int jl;
    int jt;
    int rt;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          jl = 1;
          jt = 1;
          rt = 1;
        end
        1: begin
          jl = 100;
          jt = 255;
          rt = 255;
        end
        default: begin
          jl = $urandom_range(1, 40);
          jt = $urandom_range(1, 20);
          rt = $urandom_range(1, 40);
        end
      endcase
      write_reg(bpg_pkg::REG_JUMP_LIMIT, bpg_pkg::TICK_W'(jl));
      write_reg(bpg_pkg::REG_JUMP_TICKS, bpg_pkg::TICK_W'(jt));
      write_reg(bpg_pkg::REG_RECHECK_TICKS, bpg_pkg::TICK_W'(rt));
      if (ph == 4) write_reg(REG_UNUSED, bpg_pkg::TICK_W'($urandom_range(0, 255)));
      // Both sides idle, only the sender, only the receiver, then neither.
      tx_idle_on = (ph % 4) < 2;
      rx_idle_on = (ph % 4) == 0 || (ph % 4) == 2;
      random_traffic(245);
    end
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_curve_points();
    test_reload_floor();
    test_backpressure();
    test_random_phases();

    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bpg_pkg.sv
rtl/core/bpg_cell.sv
rtl/core/bpg_window.sv
rtl/core/bpg_curve.sv
rtl/core/battery_percent_gauge.sv
sim/tb_top.sv
